@@ rtl/core/aes_prf_pkg.sv @@
// aes_prf_pkg: shared types, constants and aes helper functions
// no dependencies
`default_nettype none
package aes_prf_pkg;
  localparam int unsigned ChunkBits = 24;
  localparam int unsigned NumRounds = 10;
  localparam int unsigned LgW = 5;

  typedef enum logic [1:0] {
    REG_KEY_LOW  = 2'd0,
    REG_KEY_HIGH = 2'd1,
    REG_LOG2     = 2'd2,
    REG_COUNT    = 2'd3
  } reg_idx_e;

  // sideband carried along the round chain
  typedef struct packed {
    logic [23:0] chunk;
    logic [23:0] cand;
  } side_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd1: v = 8'h01;  4'd2: v = 8'h02;  4'd3: v = 8'h04;  4'd4: v = 8'h08;
      4'd5: v = 8'h10;  4'd6: v = 8'h20;  4'd7: v = 8'h40;  4'd8: v = 8'h80;
      4'd9: v = 8'h1b;  4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of the state sits at bits 8i+7..8i
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[8*(r+4*c) +: 8] = sbox(s[8*(r+4*((c+r)%4)) +: 8]);
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = s[32*c +: 8]; a1 = s[32*c+8 +: 8];
      a2 = s[32*c+16 +: 8]; a3 = s[32*c+24 +: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      t[32*c +: 8]    = a0 ^ al ^ xtime(a0 ^ a1);
      t[32*c+8 +: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
      t[32*c+16 +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      t[32*c+24 +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  // next round key from the previous one
  function automatic logic [127:0] key_step(input logic [127:0] k, input logic [3:0] r);
    logic [31:0] w, t;
    logic [127:0] n;
    w = k[127:96];
    t = {sbox(w[7:0]), sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]) ^ rcon(r)};
    n[31:0]   = k[31:0] ^ t;
    n[63:32]  = k[63:32] ^ n[31:0];
    n[95:64]  = k[95:64] ^ n[63:32];
    n[127:96] = k[127:96] ^ n[95:64];
    return n;
  endfunction
endpackage
`default_nettype wire

@@ rtl/core/aes_prf_keysched.sv @@
// aes_prf_keysched: round key registers, one round expanded per cycle
// depends on aes_prf_pkg
`default_nettype none
module aes_prf_keysched import aes_prf_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         load_i,
  input  wire logic [127:0] key_i,
  output logic [127:0]      rk_o [NumRounds+1],
  output logic              busy_o
);
  logic [127:0] rk_q [NumRounds+1];
  logic [3:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rk_q[0] <= '0;
      for (int i = 1; i <= NumRounds; i++) rk_q[i] <= '0;
      cnt_q <= 4'd1;
    end else if (load_i) begin
      rk_q[0] <= key_i;
      cnt_q <= 4'd1;
    end else if (cnt_q <= 4'(NumRounds)) begin
      rk_q[cnt_q] <= key_step(rk_q[cnt_q - 4'd1], cnt_q);
      cnt_q <= cnt_q + 4'd1;
    end
  end

  assign rk_o = rk_q;
  assign busy_o = (cnt_q <= 4'(NumRounds));
endmodule
`default_nettype wire

@@ rtl/core/aes_prf_cell.sv @@
// aes_prf_cell: one aes round stage of the cipher chain
// depends on aes_prf_pkg
`default_nettype none
module aes_prf_cell import aes_prf_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire logic         last_i,
  input  wire logic         vld_i,
  input  wire logic [127:0] st_i,
  input  wire side_t        sd_i,
  input  wire logic [127:0] rk_i,
  output logic              vld_o,
  output logic [127:0]      st_o,
  output side_t             sd_o
);
  logic [127:0] ss, st_d;
  always_comb begin
    ss = sub_shift(st_i);
    st_d = (last_i ? ss : mix_cols(ss)) ^ rk_i;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_o <= 1'b0;
    else if (en_i) vld_o <= vld_i;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_o <= st_d;
      sd_o <= sd_i;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/aes_prf_set_member.sv @@
// aes_prf_set_member: top level, aes-128 prf chunk offset and membership
// depends on aes_prf_pkg, aes_prf_keysched, aes_prf_cell
// Each request (set tag, chunk number, candidate offset) is encrypted as the
// 128-bit block {32'b0, tag, 40'b0, chunk} with aes-128 under the configured
// key, little-endian bytes. A chain of ten round cells plus an input stage and
// an output stage gives one result per cycle while the output is not stalled;
// the result passes through the input stage, the round cells and the output
// register. The chain advances whenever the output register is empty or being
// taken, so a stall on the output freezes the chain. A key write restarts the
// round key expansion, one round key per cycle; requests are held off in the
// write cycle and while it runs (also after reset). The low 64 ciphertext
// bits masked to 2^log2_chunk_size (capped at 24) give the chosen offset.
`default_nettype none
module aes_prf_set_member import aes_prf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] set_tag_i,
  input  wire logic [23:0] chunk_number_i,
  input  wire logic [23:0] candidate_offset_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [47:0]      element_index_o,
  output logic [23:0]      chosen_offset_o,
  output logic             is_member_o,
  output logic             is_last_chunk_o
);
  logic [63:0] key_lo_q, key_hi_q;
  logic [4:0]  lg_q;
  logic [24:0] cnt_q;
  logic        ks_load, ks_busy;
  logic [127:0] rk [NumRounds+1];

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q <= '0; key_hi_q <= '0; lg_q <= '0; cnt_q <= 25'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KEY_LOW:  key_lo_q <= cfg_data_i;
        REG_KEY_HIGH: key_hi_q <= cfg_data_i;
        REG_LOG2:     lg_q <= cfg_data_i[LgW-1:0];
        REG_COUNT:    cnt_q <= cfg_data_i[24:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ks_load = cfg_we_i && (cfg_idx_i == REG_KEY_LOW || cfg_idx_i == REG_KEY_HIGH);
  end

  aes_prf_keysched u_ks (
    .clk_i, .rst_ni, .load_i(ks_load),
    .key_i(cfg_idx_i == REG_KEY_LOW ? {key_hi_q, cfg_data_i} : {cfg_data_i, key_lo_q}),
    .rk_o(rk), .busy_o(ks_busy)
  );

  // chain advance: output register free or being drained
  logic adv;
  assign adv = !out_valid_o || out_ready_i;
  assign in_ready_o = adv && !ks_busy && !ks_load;

  // input stage: initial round key add
  logic          v_q [NumRounds+1];
  logic [127:0]  s_q [NumRounds+1];
  side_t         d_q [NumRounds+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q[0] <= 1'b0;
    else if (adv) v_q[0] <= in_valid_i && in_ready_o;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_q[0] <= {32'd0, set_tag_i, 40'd0, chunk_number_i} ^ rk[0];
      d_q[0] <= '{chunk: chunk_number_i, cand: candidate_offset_i};
    end
  end

  // round cells
  for (genvar g = 1; g <= NumRounds; g++) begin : g_rnd
    aes_prf_cell u_cell (
      .clk_i, .rst_ni, .en_i(adv), .last_i(g == NumRounds),
      .vld_i(v_q[g-1]), .st_i(s_q[g-1]), .sd_i(d_q[g-1]), .rk_i(rk[g]),
      .vld_o(v_q[g]), .st_o(s_q[g]), .sd_o(d_q[g])
    );
  end

  // output stage
  logic [4:0]  lg_c;
  logic [23:0] chosen;
  logic [24:0] last_num;
  assign lg_c = (lg_q > 5'(ChunkBits)) ? 5'(ChunkBits) : lg_q;
  assign chosen = s_q[NumRounds][23:0] & 24'((25'd1 << lg_c) - 25'd1);
  assign last_num = cnt_q - 25'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (adv) out_valid_o <= v_q[NumRounds];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      element_index_o <= 48'({24'd0, d_q[NumRounds].chunk} << lg_c) + 48'(chosen);
      chosen_offset_o <= chosen;
      is_member_o     <= d_q[NumRounds].cand == chosen;
      is_last_chunk_o <= {1'b0, d_q[NumRounds].chunk} == last_num;
    end
  end

  // no request taken while round keys are being expanded
  a_no_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ks_busy |-> !in_ready_o) else $error("request taken during key expansion");
  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(element_index_o)))
    else $error("stalled result changed");
  // chain frozen while output stalls
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(s_q[NumRounds]))
    else $error("chain moved under stall");
endmodule
`default_nettype wire
